@@ design/ilnts_pkg.sv @@
// shared types, constants and sine table for the in-lane nearest target select unit
`default_nettype none

package ilnts_pkg;

    // sine table geometry
    localparam int SINE_TABLE_BITS = 10;
    localparam int SINE_SIZE       = 1 << SINE_TABLE_BITS;
    localparam int SINE_ADDR_W     = SINE_TABLE_BITS + 1;
    localparam int SINE_W          = 15;

    // angle to quarter-turn scaling
    localparam logic [15:0] TWO_OVER_PI_Q16 = 16'd41722;
    localparam logic [63:0] HALF_PI_Q30     = 64'd1686629713;
    localparam int          Q_FRAC          = 29;
    localparam int          Q_W             = 31;

    // lateral offset product, Q16.15
    localparam int PROD_W = 16 + SINE_W;

    // front to back queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // configuration
    localparam int           CFG_ADDR_W     = 3;
    localparam logic [15:0]  LANE_HALF_RST  = 16'd461;
    localparam logic         REG_LANE_HALF  = 1'b0;

    typedef struct packed {
        logic [31:0]        frame_number;
        logic               has_target;
        logic [15:0]        target_distance;
        logic signed [15:0] target_velocity;
        logic signed [15:0] target_angle;
        logic               last_in_frame;
    } in_item_t;

    typedef struct packed {
        logic [31:0]        out_frame_number;
        logic               lead_valid;
        logic [15:0]        lead_distance;
        logic signed [15:0] lead_velocity;
        logic signed [15:0] lead_angle;
    } out_item_t;

    typedef struct packed {
        in_item_t               item;
        logic [SINE_ADDR_W-1:0] sine_addr;
    } queue_entry_t;

    typedef logic [SINE_W-1:0] sine_rom_t [0:SINE_SIZE];

    // shift and subtract quotient, used only while the table is built
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // one quarter-wave entry, taylor series in Q2.30, rounded to Q0.15
    function automatic logic [SINE_W-1:0] sine_entry(input logic [SINE_ADDR_W-1:0] i);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        div;
        logic [63:0]        r;
        logic signed [63:0] sum;
        x    = ({{(64-SINE_ADDR_W){1'b0}}, i} * HALF_PI_Q30) >> SINE_TABLE_BITS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (int k = 1; k <= 12; k++) begin
            div  = 64'(4 * k * k + 2 * k);
            term = (term * x2) >> 30;
            term = udiv64(term, div);
            if (k[0]) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        r = ($unsigned(sum) + 64'd16384) >> 15;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return r[SINE_W-1:0];
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int i = 0; i <= SINE_SIZE; i++) begin
            rom[i] = sine_entry(SINE_ADDR_W'(i));
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

@@ design/ilnts_front.sv @@
// front stage: accepts targets and maps the angle to a quarter-wave table address
`default_nettype none

module ilnts_front
    import ilnts_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire in_item_t     s_data,
    input  wire logic         q_full,
    output logic              q_push,
    output queue_entry_t      q_wr_data
);

    logic               f_valid_reg;
    logic               f_valid_next;
    in_item_t           f_item_reg;
    logic [Q_W-1:0]     f_q_reg;
    logic [15:0]        ang_bits;
    logic [15:0]        mag;
    logic [31:0]        q_full_prod;
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [SINE_ADDR_W-1:0]     addr;

    assign q_push  = f_valid_reg && !q_full;
    assign s_ready = !f_valid_reg || !q_full;

    // absolute angle times 2/pi
    always_comb begin
        ang_bits    = s_data.target_angle;
        mag         = ang_bits[15] ? 16'(17'h10000 - {1'b0, ang_bits}) : ang_bits;
        q_full_prod = 32'(mag) * 32'(TWO_OVER_PI_Q16);
    end

    always_comb begin
        f_valid_next = f_valid_reg;
        if (s_valid && s_ready) begin
            f_valid_next = 1'b1;
        end else if (q_push) begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            f_item_reg <= s_data;
            f_q_reg    <= q_full_prod[Q_W-1:0];
        end
    end

    // odd quadrants read the table mirrored
    always_comb begin
        idx  = f_q_reg[Q_FRAC-1 -: SINE_TABLE_BITS];
        addr = f_q_reg[Q_FRAC] ? SINE_ADDR_W'(SINE_SIZE) - {1'b0, idx} : {1'b0, idx};
        q_wr_data.item      = f_item_reg;
        q_wr_data.sine_addr = addr;
    end

endmodule

`default_nettype wire

@@ design/ilnts_queue.sv @@
// short fifo between the front and the back
`default_nettype none

module ilnts_queue
    import ilnts_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire queue_entry_t wr_data,
    output logic              full,
    input  wire logic         pop,
    output queue_entry_t      rd_data,
    output logic              empty
);

    queue_entry_t            mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]  wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]  wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]  rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0]  rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]  count_reg;
    logic [QUEUE_CNT_W-1:0]  count_next;

    assign full    = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    // depth is a power of two, pointers wrap on their own
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_push_only_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on push");
`endif

endmodule

`default_nettype wire

@@ design/ilnts_back.sv @@
// back pipeline: sine lookup, lateral offset, lane test and nearest target tracking
`default_nettype none

module ilnts_back
    import ilnts_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic [15:0]  lane_half_width,
    input  wire logic         q_empty,
    input  wire queue_entry_t q_rd_data,
    output logic              q_pop,
    output logic              m_valid,
    input  wire logic         m_ready,
    output out_item_t         m_data
);

    logic               en;
    logic               emit;
    logic               take;
    logic               in_lane;
    logic [PROD_W-1:0]  limit;

    logic               a_valid_reg;
    logic               a_valid_next;
    queue_entry_t       a_entry_reg;
    logic [SINE_W-1:0]  a_sine_reg;

    logic               b_valid_reg;
    logic               b_valid_next;
    in_item_t           b_item_reg;
    logic [PROD_W-1:0]  b_prod_reg;

    logic               best_found_reg;
    logic               best_found_next;
    logic [15:0]        best_distance_reg;
    logic [15:0]        best_distance_next;
    logic [15:0]        best_velocity_reg;
    logic [15:0]        best_velocity_next;
    logic [15:0]        best_angle_reg;
    logic [15:0]        best_angle_next;

    logic               upd_found;
    logic [15:0]        upd_distance;
    logic [15:0]        upd_velocity;
    logic [15:0]        upd_angle;

    logic               out_valid_reg;
    logic               out_valid_next;
    out_item_t          out_item_reg;

    // hold the whole pipe only when a frame end meets a full output register
    assign en    = !(b_valid_reg && b_item_reg.last_in_frame && out_valid_reg && !m_ready);
    assign q_pop = en && !q_empty;
    assign emit  = en && b_valid_reg && b_item_reg.last_in_frame;

    always_comb begin
        a_valid_next = en ? !q_empty   : a_valid_reg;
        b_valid_next = en ? a_valid_reg : b_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // registered table read, then the offset product
    always_ff @(posedge aclk) begin
        if (en) begin
            a_entry_reg <= q_rd_data;
            a_sine_reg  <= SINE_ROM[q_rd_data.sine_addr];
            b_item_reg  <= a_entry_reg.item;
            b_prod_reg  <= PROD_W'(a_entry_reg.item.target_distance) * PROD_W'(a_sine_reg);
        end
    end

    always_comb begin
        limit   = {lane_half_width, {SINE_W{1'b0}}};
        in_lane = (b_prod_reg <= limit);
        take    = b_valid_reg && b_item_reg.has_target && in_lane &&
                  (!best_found_reg || (b_item_reg.target_distance < best_distance_reg));
        upd_found    = take ? 1'b1                       : best_found_reg;
        upd_distance = take ? b_item_reg.target_distance : best_distance_reg;
        upd_velocity = take ? b_item_reg.target_velocity : best_velocity_reg;
        upd_angle    = take ? b_item_reg.target_angle    : best_angle_reg;
    end

    always_comb begin
        best_found_next    = best_found_reg;
        best_distance_next = best_distance_reg;
        best_velocity_next = best_velocity_reg;
        best_angle_next    = best_angle_reg;
        if (emit) begin
            best_found_next    = 1'b0;
            best_distance_next = '0;
            best_velocity_next = '0;
            best_angle_next    = '0;
        end else if (en) begin
            best_found_next    = upd_found;
            best_distance_next = upd_distance;
            best_velocity_next = upd_velocity;
            best_angle_next    = upd_angle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_found_reg    <= 1'b0;
            best_distance_reg <= '0;
            best_velocity_reg <= '0;
            best_angle_reg    <= '0;
        end else begin
            best_found_reg    <= best_found_next;
            best_distance_reg <= best_distance_next;
            best_velocity_reg <= best_velocity_next;
            best_angle_reg    <= best_angle_next;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_item_reg.out_frame_number <= b_item_reg.frame_number;
            out_item_reg.lead_valid       <= upd_found;
            out_item_reg.lead_distance    <= upd_found ? upd_distance : '0;
            out_item_reg.lead_velocity    <= upd_found ? upd_velocity : '0;
            out_item_reg.lead_angle       <= upd_found ? upd_angle    : '0;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

`ifndef SYNTHESIS
    a_frame_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> !best_found_reg)
        else $error("best target not cleared after frame end");

    a_empty_best_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !best_found_reg |-> (best_distance_reg == '0 && best_velocity_reg == '0 &&
                             best_angle_reg == '0))
        else $error("stale best target without found flag");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed while waiting");
`endif

endmodule

`default_nettype wire

@@ design/in_lane_nearest_target_select_unit.sv @@
// top level of the in-lane nearest target select unit with its register port
//
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+--------------------------------
// s_       | in        | s_valid / s_ready  | in_item_t, one radar target
// m_       | out       | m_valid / m_ready  | out_item_t, one result per frame
// apb      | in        | psel/penable/pready| lane_half_width at byte 0
//
// one target per cycle sustained while the queue has room; a frame's last
// item passes the front multiply register, the queue, the registered sine
// table read and the offset product register before m_valid rises.
// the result waits in an output register; only a frame end that finds it
// still occupied holds the back pipe, and the queue lets the front keep
// accepting until it fills. synchronous active-low reset empties all stages,
// clears the running best target and loads lane_half_width with 461.
`default_nettype none

module in_lane_nearest_target_select_unit
    import ilnts_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // target stream
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,
    // result stream
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data,
    // register port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic          lane_half_reg;
    logic [15:0]   lane_half_width_reg;
    logic [15:0]   lane_half_width_next;
    logic          cfg_wr;
    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;
    queue_entry_t  q_wr_data;
    queue_entry_t  q_rd_data;

    // register select by word index, one register in the map
    assign pready        = 1'b1;
    assign lane_half_reg = (paddr[2] == REG_LANE_HALF);
    assign cfg_wr        = psel && penable && pwrite && pready;

    always_comb begin
        lane_half_width_next = lane_half_width_reg;
        if (cfg_wr && lane_half_reg) begin
            lane_half_width_next = pwdata[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_half_width_reg <= LANE_HALF_RST;
        end else begin
            lane_half_width_reg <= lane_half_width_next;
        end
    end

    // reads outside the map return zero
    assign prdata = lane_half_reg ? {16'd0, lane_half_width_reg} : 32'd0;

    // front: accept each transaction and turn its angle into a table address
    ilnts_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_wr_data (q_wr_data)
    );

    // decoupling queue so the front keeps going while a result waits
    ilnts_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_data (q_wr_data),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    // back: offset test, nearest target tracking and the result register
    ilnts_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .lane_half_width (lane_half_width_reg),
        .q_empty         (q_empty),
        .q_rd_data       (q_rd_data),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data)
    );

endmodule

`default_nettype wire
